### src/msr_pkg.sv
// Package for the multi-servo slew ramp: field widths, opcodes, command
// kinds, configuration register indexes and shared record types.
// No dependencies.
`default_nettype none

package msr_pkg;

  // Default channel count
  localparam int CHANNELS_DEF = 4;

  // Fixed field widths
  localparam int OPCODE_W = 3;
  localparam int CHAN_W   = 2;
  localparam int VALUE_W  = 11;
  localparam int ANGLE_W  = 8;
  localparam int MASK_W   = 4;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 8;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Angle limit in degrees
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_SET_TARGET = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_IMM  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DETACH     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REHOME     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TICK       = 3'd4;

  // Classified command kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DETACH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REHOME = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd5;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_HOME0    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HOME1    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HOME2    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_HOME3    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MAX_STEP = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_MIN_STEP = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_SPEED    = 3'd6;

  // Register reset values
  localparam logic [ANGLE_W-1:0] HOME_RST     = 8'd90;
  localparam logic [ANGLE_W-1:0] MAX_STEP_RST = 8'd10;
  localparam logic [ANGLE_W-1:0] MIN_STEP_RST = 8'd2;
  localparam logic [CHAN_W-1:0]  SPEED_RST    = 2'd0;

  // Configuration register file as seen by the back end
  typedef struct packed {
    logic [3:0][ANGLE_W-1:0] home;
    logic [ANGLE_W-1:0]      max_step;
    logic [ANGLE_W-1:0]      min_step;
    logic [CHAN_W-1:0]       speed_channel;
  } cfg_regs_t;

  // One classified command in the queue
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CHAN_W-1:0]  ch;
    logic [ANGLE_W-1:0] ang;
  } cmd_rec_t;

endpackage

`default_nettype wire

### src/msr_ifs.sv
// Handshake channel interfaces: command input, result output and
// configuration writes. Depends on msr_pkg.
`default_nettype none

interface msr_cmd_if import msr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [CHAN_W-1:0]          channel;
  logic signed [VALUE_W-1:0]  angle_value;

  modport source (output valid, opcode, channel, angle_value, input ready);
  modport sink (input valid, opcode, channel, angle_value, output ready);
endinterface

interface msr_res_if import msr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_en;
  logic [CHAN_W-1:0]  out_channel;
  logic [ANGLE_W-1:0] out_angle;
  logic [MASK_W-1:0]  attached_mask;
  logic               moved;
  logic               last;

  modport source (output valid, write_en, out_channel, out_angle, attached_mask, moved, last,
                  input ready);
  modport sink (input valid, write_en, out_channel, out_angle, attached_mask, moved, last,
                output ready);
endinterface

interface msr_cfg_if import msr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/msr_front.sv
// Front end: holds the configuration registers, accepts commands, clamps
// the angle and classifies each command for the back end. Depends on msr_pkg.
`default_nettype none

module msr_front import msr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  msr_cmd_if.sink    cmd,
  msr_cfg_if.sink    cfg,
  input  wire logic  q_full,
  output logic       q_push,
  output cmd_rec_t   q_rec,
  output cfg_regs_t  regs
);

  logic [ANGLE_W-1:0] ang_clamped;
  logic               ch_ok;

  // Configuration writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.home          <= {4{HOME_RST}};
      regs.max_step      <= MAX_STEP_RST;
      regs.min_step      <= MIN_STEP_RST;
      regs.speed_channel <= SPEED_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HOME0:    regs.home[0]       <= cfg.data;
        CFG_HOME1:    regs.home[1]       <= cfg.data;
        CFG_HOME2:    regs.home[2]       <= cfg.data;
        CFG_HOME3:    regs.home[3]       <= cfg.data;
        CFG_MAX_STEP: regs.max_step      <= cfg.data;
        CFG_MIN_STEP: regs.min_step      <= cfg.data;
        CFG_SPEED:    regs.speed_channel <= cfg.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Command beat goes straight into the queue when there is room
  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;

  // Clamp to 0..180
  always_comb begin
    if (cmd.angle_value[VALUE_W-1]) begin
      ang_clamped = '0;
    end else if (cmd.angle_value[VALUE_W-2:0] > (VALUE_W-1)'(ANGLE_MAX)) begin
      ang_clamped = ANGLE_MAX;
    end else begin
      ang_clamped = cmd.angle_value[ANGLE_W-1:0];
    end
  end

  assign ch_ok = {1'b0, cmd.channel} < (CHAN_W+1)'(CHANNELS);

  // Classification
  always_comb begin
    q_rec.ch  = cmd.channel;
    q_rec.ang = ang_clamped;
    case (cmd.opcode)
      OP_SET_TARGET: begin
        if (!ch_ok) begin
          q_rec.kind = KIND_NONE;
        end else if (cmd.channel == regs.speed_channel) begin
          q_rec.kind = KIND_WRITE;
        end else begin
          q_rec.kind = KIND_TARGET;
        end
      end
      OP_WRITE_IMM: q_rec.kind = ch_ok ? KIND_WRITE : KIND_NONE;
      OP_DETACH:    q_rec.kind = KIND_DETACH;
      OP_REHOME:    q_rec.kind = KIND_REHOME;
      OP_TICK:      q_rec.kind = KIND_TICK;
      default:      q_rec.kind = KIND_NONE;
    endcase
  end

endmodule

`default_nettype wire

### src/msr_queue.sv
// Short FIFO of classified commands between front and back ends.
// Depends on msr_pkg.
`default_nettype none

module msr_queue import msr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire cmd_rec_t push_rec,
  output logic          full,
  input  wire logic     pop,
  output logic          valid,
  output cmd_rec_t      rec
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_rec_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign rec     = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/msr_back.sv
// Back end: per-channel servo state, channel sequencer for re-home and ramp
// ticks, and the result output register. Depends on msr_pkg.
`default_nettype none

module msr_back import msr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_regs_t regs,
  input  wire logic      q_valid,
  input  wire cmd_rec_t  q_rec,
  output logic           q_pop,
  msr_res_if.source      res
);

  localparam int CIW = $clog2(CHANNELS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REHOME = 2'd1;
  localparam logic [1:0] ST_TICK   = 2'd2;

  logic [1:0]          state;
  logic [CIW-1:0]      idx;
  logic [CHANNELS-1:0] attached;
  logic [CHANNELS-1:0] move_left;
  logic [ANGLE_W-1:0]  target  [CHANNELS];
  logic [ANGLE_W-1:0]  current [CHANNELS];

  // Output register
  logic                out_valid;
  logic                out_wen;
  logic [CHAN_W-1:0]   out_ch;
  logic [ANGLE_W-1:0]  out_ang;
  logic [MASK_W-1:0]   out_mask;
  logic                out_moved;
  logic                out_last;
  logic                load_ok;

  // Next result
  logic                emit;
  logic                e_wen;
  logic [CHAN_W-1:0]   e_ch;
  logic [ANGLE_W-1:0]  e_ang;
  logic [CHANNELS-1:0] e_attached;
  logic                e_moved;
  logic                e_last;

  logic [CHANNELS-1:0] move_mask;
  logic [CHANNELS-1:0] move_rest;
  logic [CIW-1:0]      q_ch;
  logic [ANGLE_W-1:0]  home_sel;
  logic [ANGLE_W-1:0]  cur_sel;
  logic [ANGLE_W-1:0]  tgt_sel;
  logic                step_up;
  logic [ANGLE_W-1:0]  adiff;
  logic [ANGLE_W-1:0]  cap;
  logic [ANGLE_W-1:0]  mag;
  logic [ANGLE_W-1:0]  cur_new;

  assign load_ok = !out_valid || res.ready;
  assign q_pop   = (state == ST_IDLE) && q_valid && load_ok;
  assign q_ch    = q_rec.ch[CIW-1:0];

  // Channels that a tick would step right now
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      move_mask[i] = attached[i] && (CHAN_W'(i) != regs.speed_channel) &&
                     (target[i] != current[i]);
    end
  end

  // Ramp step on the channel under the sequencer
  assign cur_sel = current[idx];
  assign tgt_sel = target[idx];
  assign step_up = tgt_sel > cur_sel;
  assign adiff   = step_up ? tgt_sel - cur_sel : cur_sel - tgt_sel;
  assign cap     = (regs.max_step == '0) ? ANGLE_W'(1) : regs.max_step;

  always_comb begin
    if (adiff <= regs.min_step) begin
      mag = adiff;
    end else if (adiff < cap) begin
      mag = adiff;
    end else begin
      mag = cap;
    end
  end

  assign cur_new   = step_up ? cur_sel + mag : cur_sel - mag;
  assign move_rest = move_left & ~(CHANNELS'(1) << idx);

  // Home angle, clamped
  always_comb begin
    home_sel = regs.home[2'(idx)];
    if (home_sel > ANGLE_MAX) begin
      home_sel = ANGLE_MAX;
    end
  end

  // Result selection
  always_comb begin
    emit       = 1'b0;
    e_wen      = 1'b0;
    e_ch       = '0;
    e_ang      = '0;
    e_attached = attached;
    e_moved    = 1'b0;
    e_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_rec.kind)
            KIND_WRITE: begin
              emit = 1'b1;
              if (attached[q_ch]) begin
                e_wen = 1'b1;
                e_ch  = q_rec.ch;
                e_ang = q_rec.ang;
              end
            end
            KIND_DETACH: begin
              emit       = 1'b1;
              e_attached = '0;
            end
            KIND_REHOME: emit = 1'b0;
            KIND_TICK:   emit = (move_mask == '0);
            default:     emit = 1'b1;
          endcase
        end
      end
      ST_REHOME: begin
        emit       = load_ok;
        e_wen      = 1'b1;
        e_ch       = CHAN_W'(idx);
        e_ang      = home_sel;
        e_last     = (idx == CIW'(CHANNELS-1));
      end
      ST_TICK: begin
        emit    = load_ok && move_left[idx];
        e_wen   = 1'b1;
        e_ch    = CHAN_W'(idx);
        e_ang   = cur_new;
        e_moved = 1'b1;
        e_last  = (move_rest == '0);
      end
      default: ;
    endcase
  end

  // Sequencer and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      attached  <= '0;
      move_left <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        target[i]  <= '0;
        current[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            idx <= '0;
            case (q_rec.kind)
              KIND_TARGET: target[q_ch] <= q_rec.ang;
              KIND_WRITE: begin
                if (attached[q_ch]) begin
                  current[q_ch] <= q_rec.ang;
                end
              end
              KIND_DETACH: attached <= '0;
              KIND_REHOME: begin
                attached <= '1;
                state    <= ST_REHOME;
              end
              KIND_TICK: begin
                move_left <= move_mask;
                if (move_mask != '0) begin
                  state <= ST_TICK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_REHOME: begin
          if (load_ok) begin
            target[idx]  <= home_sel;
            current[idx] <= home_sel;
            if (idx == CIW'(CHANNELS-1)) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_TICK: begin
          if (load_ok) begin
            if (move_left[idx]) begin
              current[idx] <= cur_new;
              move_left    <= move_rest;
            end
            if (move_rest == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && emit) begin
      out_wen   <= e_wen;
      out_ch    <= e_ch;
      out_ang   <= e_ang;
      out_mask  <= MASK_W'(e_attached);
      out_moved <= e_moved;
      out_last  <= e_last;
    end
  end

  assign res.valid         = out_valid;
  assign res.write_en      = out_wen;
  assign res.out_channel   = out_ch;
  assign res.out_angle     = out_ang;
  assign res.attached_mask = out_mask;
  assign res.moved         = out_moved;
  assign res.last          = out_last;

  // Checks
  a_rehome_attaches: assert property (@(posedge clk) disable iff (rst)
    q_pop && (q_rec.kind == KIND_REHOME) |=> (attached == {CHANNELS{1'b1}}))
    else $error("re-home did not attach all channels");

  a_tick_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK) |-> (move_left != '0))
    else $error("tick sequencer running with nothing to move");

  a_pop_makes_progress: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != ST_IDLE) || out_valid)
    else $error("command popped without result or sequencer activity");

  a_moved_is_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_moved |-> out_wen)
    else $error("moved flag on a result that is not a write");

endmodule

`default_nettype wire

### src/multi_servo_slew_ramp_core.sv
// Top level of the multi-servo slew ramp: front end, command queue and
// back end. Depends on msr_pkg, msr_ifs, msr_front, msr_queue, msr_back.
//
// Four-channel servo slew-rate limiter. Commands (set target, write now,
// detach all, re-attach and home, ramp tick) enter on cmd and are queued two
// deep; every PWM write leaves on res as one beat, with last on the final beat
// of each command, and a command that writes nothing gives one beat with
// write_en low. The back end visits one channel a cycle while res is not
// stalled: a moving tick visits the channels from the first up to the last
// channel that moves, and re-home visits every channel in turn. Registers
// on cfg may be written only while idle.
`default_nettype none

module multi_servo_slew_ramp_core import msr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  msr_cmd_if.sink    cmd,
  msr_res_if.source  res,
  msr_cfg_if.sink    cfg
);

  cfg_regs_t regs;
  cmd_rec_t  push_rec;
  cmd_rec_t  pop_rec;
  logic      q_push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  msr_front #(.CHANNELS(CHANNELS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (push_rec),
    .regs   (regs)
  );

  msr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .rec      (pop_rec)
  );

  msr_back #(.CHANNELS(CHANNELS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .q_valid (q_valid),
    .q_rec   (pop_rec),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

### bench/multi_servo_slew_ramp_core_tb.sv
// Self-checking bench for the four-channel servo slew ramp core: directed
// table, then randomised command phases under several register settings.
// Depends on msr_pkg, msr_ifs and multi_servo_slew_ramp_core.
module multi_servo_slew_ramp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msr_pkg::*;

  // Opcodes that the core must ignore
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  // Row kinds of the directed table
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 45;

  // One result beat, field for field
  typedef struct packed {
    logic               write_en;
    logic [CHAN_W-1:0]  out_channel;
    logic [ANGLE_W-1:0] out_angle;
    logic [MASK_W-1:0]  attached_mask;
    logic               moved;
    logic               last;
  } servo_beat_t;

  typedef struct {
    logic [OPCODE_W-1:0]       op;
    logic [CHAN_W-1:0]         ch;
    logic signed [VALUE_W-1:0] val;
    bit                        typed;
    servo_beat_t               beat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic res_rdy = 1'b0;
  int   stall_cnt = 0;

  msr_cmd_if cmd ();
  msr_res_if res ();
  msr_cfg_if cfg ();

  assign res.ready = res_rdy;

  multi_servo_slew_ramp_core #(.CHANNELS(CHANNELS_DEF)) uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg)
  );

  // Shadow state of the servo channels and the registers
  logic [ANGLE_W-1:0] tgt_ang [CHANNELS_DEF];
  logic [ANGLE_W-1:0] cur_ang [CHANNELS_DEF];
  logic [MASK_W-1:0]  attached;
  logic [ANGLE_W-1:0] home_reg [CHANNELS_DEF];
  logic [ANGLE_W-1:0] max_step_reg;
  logic [ANGLE_W-1:0] min_step_reg;
  logic [CHAN_W-1:0]  speed_reg;

  servo_beat_t step_beats [CHANNELS_DEF];
  servo_beat_t expected_pwm_beats [$];
  bit          typed_q [$];
  servo_beat_t typed_beat_q [$];
  stim_row_t   dir_rows [$];

  int mismatches = 0;
  int cmds_seen = 0;
  int beats_seen = 0;
  int pwm_writes = 0;
  int cmd_gap_odds = 0;
  int res_stall_odds = 0;

  // Clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [ANGLE_W-1:0] clamp_deg(input logic signed [VALUE_W-1:0] v);
    if (v < 0) return '0;
    if (int'(v) > int'(ANGLE_MAX)) return ANGLE_MAX;
    return v[ANGLE_W-1:0];
  endfunction

  // Works out the PWM beats one command causes and updates the shadow state
  function automatic int predict_servo_writes(input logic [OPCODE_W-1:0] op,
                                              input logic [CHAN_W-1:0] ch,
                                              input logic signed [VALUE_W-1:0] val);
    logic [ANGLE_W-1:0] ang;
    logic [ANGLE_W-1:0] h;
    logic               mv;
    int                 n;
    int                 cap, diff, adiff, mag;
    ang = clamp_deg(val);
    mv  = 1'b0;
    n   = 0;
    case (op)
      OP_SET_TARGET, OP_WRITE_IMM: begin
        if (op == OP_SET_TARGET && ch != speed_reg) begin
          tgt_ang[ch] = ang;
        end else if (attached[ch]) begin
          cur_ang[ch] = ang;
          step_beats[n] = '{1'b1, ch, ang, '0, 1'b0, 1'b0};
          n++;
        end
      end
      OP_DETACH: attached = '0;
      OP_REHOME: begin
        for (int i = 0; i < CHANNELS_DEF; i++) begin
          h = (home_reg[i] > ANGLE_MAX) ? ANGLE_MAX : home_reg[i];
          attached[i] = 1'b1;
          tgt_ang[i]  = h;
          cur_ang[i]  = h;
          step_beats[n] = '{1'b1, CHAN_W'(i), h, '0, 1'b0, 1'b0};
          n++;
        end
      end
      OP_TICK: begin
        cap = (max_step_reg == '0) ? 1 : int'(max_step_reg);
        for (int i = 0; i < CHANNELS_DEF; i++) begin
          if (i == int'(speed_reg) || !attached[i]) continue;
          diff = int'(tgt_ang[i]) - int'(cur_ang[i]);
          if (diff == 0) continue;
          adiff = (diff < 0) ? -diff : diff;
          // small gaps close in one go, larger ones are capped
          if (adiff <= int'(min_step_reg)) mag = adiff;
          else mag = (adiff < cap) ? adiff : cap;
          cur_ang[i] = ANGLE_W'(int'(cur_ang[i]) + ((diff > 0) ? mag : -mag));
          step_beats[n] = '{1'b1, CHAN_W'(i), cur_ang[i], '0, 1'b0, 1'b0};
          n++;
          mv = 1'b1;
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      step_beats[0] = '0;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      step_beats[k].attached_mask = attached;
      step_beats[k].moved         = mv;
      step_beats[k].last          = (k == n - 1);
    end
    return n;
  endfunction

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || res_stall_odds == 0) begin
      res_rdy   <= 1'b1;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      res_rdy   <= (stall_cnt == 1);
    end else if ($urandom_range(0, 99) < res_stall_odds) begin
      res_rdy   <= 1'b0;
      stall_cnt <= $urandom_range(1, 14);
    end else begin
      res_rdy <= 1'b1;
    end
  end

  // Watches all three channels: register writes, accepted commands, result beats
  always @(posedge clk) begin : watch
    int          n;
    bit          typed;
    servo_beat_t hint, got, want;
    if (rst) begin
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        tgt_ang[i]  = '0;
        cur_ang[i]  = '0;
        home_reg[i] = HOME_RST;
      end
      attached     = '0;
      max_step_reg = MAX_STEP_RST;
      min_step_reg = MIN_STEP_RST;
      speed_reg    = SPEED_RST;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_HOME0:    home_reg[0]  = cfg.data;
          CFG_HOME1:    home_reg[1]  = cfg.data;
          CFG_HOME2:    home_reg[2]  = cfg.data;
          CFG_HOME3:    home_reg[3]  = cfg.data;
          CFG_MAX_STEP: max_step_reg = cfg.data;
          CFG_MIN_STEP: min_step_reg = cfg.data;
          CFG_SPEED:    speed_reg    = cfg.data[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        typed = typed_q.pop_front();
        hint  = typed_beat_q.pop_front();
        n = predict_servo_writes(cmd.opcode, cmd.channel, cmd.angle_value);
        cmds_seen++;
        if (typed) expected_pwm_beats.push_back(hint);
        else for (int k = 0; k < n; k++) expected_pwm_beats.push_back(step_beats[k]);
      end
      if (res.valid && res.ready) begin
        got = '{res.write_en, res.out_channel, res.out_angle, res.attached_mask,
                res.moved, res.last};
        beats_seen++;
        if (got.write_en === 1'b1) pwm_writes++;
        if (expected_pwm_beats.size() == 0) begin
          if (mismatches < 10)
            $display("%t: unexpected beat we=%0d ch=%0d ang=%0d mask=%h moved=%0d last=%0d",
                     $realtime, got.write_en, got.out_channel, got.out_angle,
                     got.attached_mask, got.moved, got.last);
          mismatches++;
        end else begin
          want = expected_pwm_beats.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%t: beat %0d mismatch", $realtime, beats_seen);
              $display("  exp we=%0d ch=%0d ang=%0d mask=%h moved=%0d last=%0d",
                       want.write_en, want.out_channel, want.out_angle,
                       want.attached_mask, want.moved, want.last);
              $display("  got we=%0d ch=%0d ang=%0d mask=%h moved=%0d last=%0d",
                       got.write_en, got.out_channel, got.out_angle,
                       got.attached_mask, got.moved, got.last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  function automatic void add_row(input logic [OPCODE_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                  input logic signed [VALUE_W-1:0] val, input bit typed,
                                  input logic we, input logic [CHAN_W-1:0] oc,
                                  input logic [ANGLE_W-1:0] oa, input logic [MASK_W-1:0] mask);
    stim_row_t r;
    r.op    = op;
    r.ch    = ch;
    r.val   = val;
    r.typed = typed;
    r.beat  = '{we, oc, oa, mask, 1'b0, 1'b1};
    dir_rows.push_back(r);
  endfunction

  // Drives one command beat and holds it until accepted
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [CHAN_W-1:0] ch,
                          input logic signed [VALUE_W-1:0] val, input bit typed,
                          input servo_beat_t beat);
    typed_q.push_back(typed);
    typed_beat_q.push_back(beat);
    if (cmd_gap_odds != 0 && $urandom_range(0, 99) < cmd_gap_odds) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.opcode      <= op;
    cmd.channel     <= ch;
    cmd.angle_value <= val;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  // Leaves valid high between back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Lets the monitor queue the beats of the last command, then waits for them all
  task automatic drain_results();
    @(posedge clk);
    while (expected_pwm_beats.size() != 0) @(posedge clk);
    repeat (CHANNELS_DEF + 2) @(posedge clk);
  endtask

  // Random command: mostly targets and ticks on random channels, some noise
  task automatic random_cmd();
    logic [OPCODE_W-1:0]       op;
    logic signed [VALUE_W-1:0] val;
    int                        r;
    r = $urandom_range(0, 99);
    if (r < 28) op = OP_SET_TARGET;
    else if (r < 40) op = OP_WRITE_IMM;
    else if (r < 78) op = OP_TICK;
    else if (r < 84) op = OP_DETACH;
    else if (r < 93) op = OP_REHOME;
    else op = OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    r = $urandom_range(0, 9);
    if (r < 8) val = VALUE_W'($urandom_range(0, 180));
    else if (r < 9) val = VALUE_W'($urandom_range(0, 2047));
    else begin
      case ($urandom_range(0, 5))
        0: val = -11'sd1024;
        1: val = -11'sd1;
        2: val = 11'sd0;
        3: val = 11'sd180;
        4: val = 11'sd181;
        default: val = 11'sd1023;
      endcase
    end
    send_cmd(op, CHAN_W'($urandom_range(0, 3)), val, PREDICTED, '0);
  endtask

  // Stimulus
  initial begin
    logic [ANGLE_W-1:0] hv [CHANNELS_DEF];
    logic [ANGLE_W-1:0] mx, mn;
    logic [CHAN_W-1:0]  sp;
    cmd.valid       = 1'b0;
    cmd.opcode      = OP_TICK;
    cmd.channel     = '0;
    cmd.angle_value = '0;
    cfg.valid       = 1'b0;
    cfg.index       = CFG_HOME0;
    cfg.data        = '0;
    rst             = 1'b1;

    // Directed table; expected beat typed only where obvious
    add_row(OP_TICK,       2'd0, 11'sd0,     TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_WRITE_IMM,  2'd1, 11'sd50,    TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_SET_TARGET, 2'd0, 11'sd100,   TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_SET_TARGET, 2'd2, 11'sd77,    TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_DETACH,     2'd0, 11'sd0,     TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_UNUSED_LO,  2'd1, 11'sd300,   TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_UNUSED_HI,  2'd3, -11'sd1,    TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_REHOME,     2'd0, 11'sd0,     PREDICTED, 1'b0, 2'd0, 8'd0, 4'h0);
    add_row(OP_WRITE_IMM,  2'd1, -11'sd1024, TYPED, 1'b1, 2'd1, 8'd0,   4'hF);
    add_row(OP_WRITE_IMM,  2'd2, 11'sd1023,  TYPED, 1'b1, 2'd2, 8'd180, 4'hF);
    add_row(OP_WRITE_IMM,  2'd3, 11'sd181,   TYPED, 1'b1, 2'd3, 8'd180, 4'hF);
    add_row(OP_WRITE_IMM,  2'd0, 11'sd180,   TYPED, 1'b1, 2'd0, 8'd180, 4'hF);
    add_row(OP_SET_TARGET, 2'd1, 11'sd1023,  TYPED, 1'b0, 2'd0, 8'd0,   4'hF);
    add_row(OP_SET_TARGET, 2'd2, 11'sd0,     TYPED, 1'b0, 2'd0, 8'd0,   4'hF);
    add_row(OP_SET_TARGET, 2'd3, 11'sd91,    TYPED, 1'b0, 2'd0, 8'd0,   4'hF);
    // set target on the speed channel writes straight away
    add_row(OP_SET_TARGET, 2'd0, 11'sd45,    TYPED, 1'b1, 2'd0, 8'd45,  4'hF);
    add_row(OP_TICK,       2'd0, 11'sd0,     PREDICTED, 1'b0, 2'd0, 8'd0, 4'h0);
    add_row(OP_TICK,       2'd0, 11'sd0,     PREDICTED, 1'b0, 2'd0, 8'd0, 4'h0);
    add_row(OP_TICK,       2'd0, 11'sd0,     PREDICTED, 1'b0, 2'd0, 8'd0, 4'h0);
    add_row(OP_TICK,       2'd0, 11'sd0,     PREDICTED, 1'b0, 2'd0, 8'd0, 4'h0);
    // one degree short of target: snaps on the next tick
    add_row(OP_SET_TARGET, 2'd1, 11'sd41,    TYPED, 1'b0, 2'd0, 8'd0,   4'hF);
    add_row(OP_TICK,       2'd0, 11'sd0,     PREDICTED, 1'b0, 2'd0, 8'd0, 4'h0);
    add_row(OP_DETACH,     2'd0, 11'sd0,     TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_TICK,       2'd0, 11'sd0,     TYPED, 1'b0, 2'd0, 8'd0,   4'h0);
    add_row(OP_WRITE_IMM,  2'd0, 11'sd7,     TYPED, 1'b0, 2'd0, 8'd0,   4'h0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    cmd_gap_odds   = 25;
    res_stall_odds = 10;
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].val, dir_rows[i].typed,
               dir_rows[i].beat);
    cmd.valid <= 1'b0;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin hv = '{8'd0, 8'd180, 8'd255, 8'd90}; mx = 8'd0;   mn = 8'd0;   sp = 2'd3; end
        1: begin hv = '{8'd180, 8'd0, 8'd200, 8'd1}; mx = 8'd180; mn = 8'd180; sp = 2'd1; end
        2: begin hv = '{8'd255, 8'd181, 8'd0, 8'd180}; mx = 8'd255; mn = 8'd255; sp = 2'd2; end
        3: begin
          hv = '{HOME_RST, HOME_RST, HOME_RST, HOME_RST};
          mx = MAX_STEP_RST;
          mn = MIN_STEP_RST;
          sp = SPEED_RST;
        end
        default: begin
          foreach (hv[i]) hv[i] = ANGLE_W'($urandom_range(0, 200));
          mx = ANGLE_W'($urandom_range(1, 24));
          mn = ANGLE_W'($urandom_range(0, 12));
          sp = CHAN_W'($urandom_range(0, 3));
        end
      endcase
      for (int k = 0; k < CHANNELS_DEF; k++) write_reg(CIDX_W'(CFG_HOME0 + k), hv[k]);
      write_reg(CFG_MAX_STEP, mx);
      write_reg(CFG_MIN_STEP, mn);
      write_reg(CFG_SPEED, CDATA_W'(sp));
      cfg.valid <= 1'b0;

      // vary the idling; the closing phase runs flat out
      cmd_gap_odds   = (ph == PHASES - 1 || ph % 3 == 2) ? 0 : $urandom_range(5, 30);
      res_stall_odds = (ph == PHASES - 1 || ph % 3 == 1) ? 0 : $urandom_range(3, 15);

      send_cmd(OP_REHOME, '0, '0, PREDICTED, '0);
      for (int k = 1; k < ITEMS_PER_PHASE; k++) random_cmd();
      cmd.valid <= 1'b0;
    end

    drain_results();
    if (expected_pwm_beats.size() != 0) begin
      $display("%0d expected beats never arrived", expected_pwm_beats.size());
      mismatches += expected_pwm_beats.size();
    end
    $display("Covered %0d commands and %0d result beats (%0d PWM writes) over %0d settings,",
             cmds_seen, beats_seen, pwm_writes, PHASES + 1);
    $display("with %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
